[design/ptrt_pkg.sv]
// ----------------------------------------------------------------------------
// ptrt_pkg
// Shared types and constants for the periodic task release table.
// ----------------------------------------------------------------------------
package ptrt_pkg;

    localparam int REG_COUNT  = 6;   // number of period registers
    localparam int CHAN_MAX   = 6;   // largest supported channel count
    localparam int PERIOD_W   = 16;
    localparam int TIME_W     = 32;
    localparam int TASK_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;

    // Period register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET [REG_COUNT] = '{
        16'd1, 16'd2, 16'd5, 16'd10, 16'd50, 16'd100
    };

    // Request codes
    localparam logic REQ_SYNC = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] now_time;
    } req_t;

    typedef struct packed {
        logic [TASK_IDX_W-1:0] task_index;
        logic                  task_due;
        logic                  last;
    } result_t;

    // Memory command group
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic sync_en;
    } mem_ctl_t;

endpackage

[design/ptrt_cfg.sv]
// ----------------------------------------------------------------------------
// ptrt_cfg
// Period register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module ptrt_cfg
    import ptrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [PERIOD_W-1:0]  wr_data,
    output logic [PERIOD_W-1:0]  period [REG_COUNT]
);

    logic [PERIOD_W-1:0] period_reg [REG_COUNT];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                period_reg[i] <= PERIOD_RESET[i];
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                if (wr_index == CFG_IDX_W'(i))
                begin
                    period_reg[i] <= wr_data;
                end
            end
        end
    end

    assign period = period_reg;

endmodule

[design/ptrt_mem.sv]
// ----------------------------------------------------------------------------
// ptrt_mem
// Last-release time store: synchronous RAM with a registered read.
// Entries not written since the last sync (or reset) read as the sync time.
// ----------------------------------------------------------------------------
module ptrt_mem
    import ptrt_pkg::*;
#(
    parameter int DEPTH = CHAN_MAX,
    parameter int AW    = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_ctl_t          ctl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  logic [TIME_W-1:0] wr_data,
    input  logic [TIME_W-1:0] sync_time,
    output logic [TIME_W-1:0] rd_data
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_q_reg;
    logic              rd_vld_reg;
    logic [DEPTH-1:0]  vld_reg;
    logic [TIME_W-1:0] base_reg;

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Written flags and sync base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            base_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (ctl.sync_en)
            begin
                vld_reg  <= '0;
                base_reg <= sync_time;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // base_reg cannot change during a poll, so it is safe to select late
    assign rd_data = rd_vld_reg ? rd_q_reg : base_reg;

endmodule

[design/periodic_task_release_table_core.sv]
// ----------------------------------------------------------------------------
// periodic_task_release_table_core
// Poll walks the channels through the release-time RAM, one per cycle.
// ----------------------------------------------------------------------------
// Sync item: no result; busy stays low.
// Poll item: busy through the POLL and FLUSH states, during the
//   one-channel-per-cycle read/modify/write walk of the release-time RAM.
//   Results are registered; the last one comes out of the FLUSH state.
// Results are one-cycle strobes; the receiver cannot stall them.
// Reset: periods to defaults, release times read as zero, FSM idle.
module periodic_task_release_table_core
    import ptrt_pkg::*;
#(
    parameter int CHANNELS = CHAN_MAX
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  req_t                 req,
    output logic                 result_valid,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_POLL  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   now_reg;
    logic [CH_W-1:0]     rd_ch_reg, rd_ch_next;
    logic                rd_act_reg, rd_act_next;
    logic [CH_W-1:0]     s1_ch_reg;
    logic                s1_vld_reg;
    logic [CH_W-1:0]     pend_ch_reg, pend_ch_next;
    logic                pend_vld_reg, pend_vld_next;
    logic                res_vld_reg, res_vld_next;
    result_t             res_reg, res_next;

    logic [PERIOD_W-1:0] period [REG_COUNT];
    logic [PERIOD_W-1:0] per;
    logic [TIME_W-1:0]   lrt;
    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W-1:0]   per32;
    logic [TIME_W-1:0]   per2;
    logic                due;
    logic                late;
    logic [TIME_W-1:0]   wr_data;
    logic                accept;
    mem_ctl_t            mem_ctl;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Period registers
    ptrt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .period   (period)
    );

    // Release-time store
    ptrt_mem #(
        .DEPTH (CHANNELS),
        .AW    (CH_W)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mem_ctl),
        .rd_addr   (rd_ch_reg),
        .wr_addr   (s1_ch_reg),
        .wr_data   (wr_data),
        .sync_time (req.now_time),
        .rd_data   (lrt)
    );

    // Release check for the channel returned by the RAM
    assign per     = period[s1_ch_reg];
    assign per32   = {{(TIME_W-PERIOD_W){1'b0}}, per};
    assign per2    = {{(TIME_W-PERIOD_W-1){1'b0}}, per, 1'b0};
    assign elapsed = now_reg - lrt;
    assign due     = (elapsed >= per32);
    assign late    = (elapsed >= per2);
    assign wr_data = late ? now_reg : (lrt + per32);

    always_comb
    begin
        mem_ctl.rd_en   = (state_reg == ST_POLL) && rd_act_reg;
        mem_ctl.wr_en   = s1_vld_reg && due;
        mem_ctl.sync_en = accept && (req.req_type == REQ_SYNC);
    end

    // Sequencer and result staging
    always_comb
    begin
        state_next    = state_reg;
        rd_ch_next    = rd_ch_reg;
        rd_act_next   = rd_act_reg;
        pend_ch_next  = pend_ch_reg;
        pend_vld_next = pend_vld_reg;
        res_vld_next  = 1'b0;
        res_next      = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == REQ_POLL))
                begin
                    state_next    = ST_POLL;
                    rd_ch_next    = '0;
                    rd_act_next   = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            ST_POLL:
            begin
                if (rd_act_reg)
                begin
                    if (rd_ch_reg == CH_LAST)
                    begin
                        rd_act_next = 1'b0;
                    end
                    else
                    begin
                        rd_ch_next = rd_ch_reg + 1'b1;
                    end
                end
                if (s1_vld_reg)
                begin
                    // a newly due channel pushes out the held one
                    if (due)
                    begin
                        if (pend_vld_reg)
                        begin
                            res_vld_next        = 1'b1;
                            res_next.task_index = TASK_IDX_W'(pend_ch_reg);
                            res_next.task_due   = 1'b1;
                            res_next.last       = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_ch_next  = s1_ch_reg;
                    end
                    if (s1_ch_reg == CH_LAST)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                // held channel goes out as last, or the not-due result
                res_vld_next = 1'b1;
                res_next.last = 1'b1;
                if (pend_vld_reg)
                begin
                    res_next.task_index = TASK_IDX_W'(pend_ch_reg);
                    res_next.task_due   = 1'b1;
                end
                else
                begin
                    res_next.task_index = '0;
                    res_next.task_due   = 1'b0;
                end
                pend_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_ch_reg    <= '0;
            rd_act_reg   <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s1_ch_reg    <= '0;
            pend_vld_reg <= 1'b0;
            pend_ch_reg  <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_ch_reg    <= rd_ch_next;
            rd_act_reg   <= rd_act_next;
            s1_vld_reg   <= mem_ctl.rd_en;
            s1_ch_reg    <= rd_ch_reg;
            pend_vld_reg <= pend_vld_next;
            pend_ch_reg  <= pend_ch_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            now_reg <= req.now_time;
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for periodic_task_release_table_core. Sync and poll items go in
// through the start/busy handshake. The period registers are written through
// the config channel. A model of the release table in this file predicts the
// released channels of every poll, and each result strobe is checked in
// order against that prediction.
// ----------------------------------------------------------------------------
module tb_top
    import ptrt_pkg::*;
();

    localparam int          NUM_CHANNELS   = CHAN_MAX;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          WATCHDOG_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    req_t                 req;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PERIOD_W-1:0]  cfg_data;

    // Model of the release table
    logic [PERIOD_W-1:0]  period_shadow  [REG_COUNT];
    logic [TIME_W-1:0]    release_shadow [REG_COUNT];
    result_t              pending_results [$];

    logic [TIME_W-1:0]    tick;          // running millisecond time of the traffic
    int                   fail_count;
    int                   quiet_cycles;

    periodic_task_release_table_core #(
        .CHANNELS (NUM_CHANNELS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Work out the results of one accepted item and update the table
    task automatic predict_request(input req_t item);
        result_t           batch [NUM_CHANNELS];
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] elapsed;
        int                n;
        int                i;
        n = 0;
        if (item.req_type == REQ_SYNC)
        begin
            for (i = 0; i < REG_COUNT; i++)
                release_shadow[i] = item.now_time;
        end
        else
        begin
            for (i = 0; i < NUM_CHANNELS; i++)
            begin
                per     = {{(TIME_W-PERIOD_W){1'b0}}, period_shadow[i]};
                elapsed = item.now_time - release_shadow[i];
                if (elapsed >= per)
                begin
                    release_shadow[i] = release_shadow[i] + per;
                    // fell two periods behind: catch up to now
                    if (elapsed >= (per << 1))
                        release_shadow[i] = item.now_time;
                    batch[n].task_index = i[TASK_IDX_W-1:0];
                    batch[n].task_due   = 1'b1;
                    batch[n].last       = 1'b0;
                    n++;
                end
            end
            if (n == 0)
            begin
                batch[0].task_index = '0;
                batch[0].task_due   = 1'b0;
                batch[0].last       = 1'b1;
                n = 1;
            end
            else
                batch[n-1].last = 1'b1;
            for (i = 0; i < n; i++)
                pending_results.push_back(batch[i]);
        end
    endtask

    // Send one item; start is left high so the next item can follow at once
    task automatic issue_request(input logic kind, input logic [TIME_W-1:0] now);
        req.req_type = kind;
        req.now_time = now;
        start        = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_request(req);
        @(negedge clk);
    endtask

    task automatic hold_off(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Let every expected result arrive, then let the block go quiet
    task automatic settle();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_period(input logic [CFG_IDX_W-1:0] idx,
                                input logic [PERIOD_W-1:0] data);
        start     = 1'b0;
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        // indexes past the register list are dropped
        if (idx < REG_COUNT)
            period_shadow[idx] = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Start a fresh epoch, sometimes just below the 32-bit wrap
    task automatic resync(input bit near_wrap);
        if (near_wrap)
            tick = 32'hFFFF_FFFF - $urandom_range(0, 500);
        else
            tick = $urandom;
        issue_request(REQ_SYNC, tick);
    endtask

    // Mostly a forward-running clock with polls; some resyncs, stray and stale times
    task automatic random_traffic(input int count, input int unsigned span,
                                  input bit idle_on);
        int          k;
        int unsigned pick;
        for (k = 0; k < count; k++)
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 4));
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                tick = $urandom;
                issue_request(REQ_SYNC, tick);
            end
            else if (pick < 8)
                issue_request(REQ_SYNC, tick);
            else if (pick < 13)
                issue_request(REQ_POLL, $urandom);
            else if (pick < 17)
                issue_request(REQ_POLL, tick - $urandom_range(1, span));
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    tick = tick + $urandom_range(0, 3);
                else if (pick < 8)
                    tick = tick + $urandom_range(0, span);
                else if (pick < 9)
                    tick = tick + $urandom_range(span, 3 * span);
                else
                    tick = tick + $urandom;
                issue_request(REQ_POLL, tick);
            end
        end
    endtask

    // Reset periods, first releases, exact two-period catch-up, wrap of the time
    task automatic test_default_periods();
        issue_request(REQ_POLL, 32'd0);
        issue_request(REQ_POLL, 32'd1);
        issue_request(REQ_POLL, 32'd2);
        issue_request(REQ_POLL, 32'd100);
        issue_request(REQ_POLL, 32'hFFFF_FFFF);
    endtask

    // Elapsed time across the 32-bit wrap
    task automatic test_time_wrap();
        issue_request(REQ_SYNC, 32'hFFFF_FFF0);
        issue_request(REQ_POLL, 32'hFFFF_FFF1);
        issue_request(REQ_POLL, 32'h0000_0005);
        issue_request(REQ_POLL, 32'h0000_0005);
    endtask

    // Zero and full-scale periods, ignored register indexes
    task automatic test_period_extremes();
        settle();
        write_period(3'd0, 16'h0000);
        write_period(3'd1, 16'h0001);
        write_period(3'd2, 16'hFFFF);
        write_period(3'd3, 16'h8000);
        write_period(3'd4, 16'h7FFF);
        write_period(3'd5, 16'hFFFF);
        write_period(3'd6, 16'h1234);
        write_period(3'd7, 16'hFFFF);
        issue_request(REQ_SYNC, 32'h8000_0000);
        issue_request(REQ_POLL, 32'h8000_0000);
        issue_request(REQ_POLL, 32'h8000_7FFF);
        issue_request(REQ_POLL, 32'h8000_FFFF);
        issue_request(REQ_POLL, 32'h8001_FFFE);
        issue_request(REQ_SYNC, 32'h0000_0000);
        issue_request(REQ_POLL, 32'hFFFF_FFFF);
    endtask

    task automatic test_short_periods();
        int i;
        settle();
        for (i = 0; i < REG_COUNT; i++)
            write_period(CFG_IDX_W'(i), PERIOD_W'($urandom_range(1, 8)));
        resync(1'b1);
        random_traffic(80, 16, 1'b1);
    endtask

    task automatic test_default_traffic();
        int i;
        settle();
        for (i = 0; i < REG_COUNT; i++)
            write_period(CFG_IDX_W'(i), PERIOD_RESET[i]);
        resync(1'b0);
        random_traffic(80, 120, 1'b1);
    endtask

    // Each channel gets zero, one, a moderate period or full scale
    task automatic test_mixed_periods();
        int i;
        settle();
        for (i = 0; i < REG_COUNT; i++)
        begin
            case ($urandom_range(0, 3))
                0:       write_period(CFG_IDX_W'(i), 16'h0000);
                1:       write_period(CFG_IDX_W'(i), 16'h0001);
                2:       write_period(CFG_IDX_W'(i), PERIOD_W'($urandom_range(2, 300)));
                default: write_period(CFG_IDX_W'(i), 16'hFFFF);
            endcase
        end
        write_period(CFG_IDX_W'($urandom_range(REG_COUNT, 7)), PERIOD_W'($urandom));
        resync(1'b1);
        random_traffic(70, 400, 1'b1);
    endtask

    task automatic test_full_range();
        int i;
        settle();
        for (i = 0; i < REG_COUNT; i++)
            write_period(CFG_IDX_W'(i), PERIOD_W'($urandom));
        resync(1'b0);
        random_traffic(60, 70000, 1'b1);
    endtask

    // Polls back to back with no idle cycles
    task automatic test_back_to_back();
        int i;
        settle();
        for (i = 0; i < REG_COUNT; i++)
            write_period(CFG_IDX_W'(i), PERIOD_W'($urandom_range(1, 20)));
        resync(1'b0);
        random_traffic(90, 40, 1'b0);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: task_index %0d task_due %0b last %0b",
                       result.task_index, result.task_due, result.last);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.task_index !== want.task_index)
                begin
                    $error("task_index mismatch: expected %0d, actual %0d",
                           want.task_index, result.task_index);
                    fail_count++;
                end
                if (result.task_due !== want.task_due)
                begin
                    $error("task_due mismatch: expected %0b, actual %0b",
                           want.task_due, result.task_due);
                    fail_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last mismatch: expected %0b, actual %0b",
                           want.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long with no handshake of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence
    initial
    begin
        int i;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        fail_count   = 0;
        tick         = '0;
        for (i = 0; i < REG_COUNT; i++)
        begin
            period_shadow[i]  = PERIOD_RESET[i];
            release_shadow[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_default_periods();
        test_time_wrap();
        test_period_extremes();
        test_short_periods();
        test_default_traffic();
        test_mixed_periods();
        test_full_range();
        test_back_to_back();

        settle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[periodic_task_release_table_core.f]
design/ptrt_pkg.sv
design/ptrt_cfg.sv
design/ptrt_mem.sv
design/periodic_task_release_table_core.sv
tb/tb_top.sv
